/* src/skf_pkg.sv */
// shared types, constants and the control program of the scalar kalman filter
// no dependencies; imported by skf_seq, skf_dpath and scalar_kalman_filter_top

package skf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PC_W      = 4;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // whole number to fixed point, saturating where the shift overflows
    function automatic logic [DATA_W-1:0] fix_of_int(input logic [DATA_W-1:0] whole);
        logic [2*DATA_W-1:0] v;
        v = {{DATA_W{1'b0}}, whole} << FRAC_BITS;
        return (v[2*DATA_W-1:DATA_W] != '0) ? {DATA_W{1'b1}} : v[DATA_W-1:0];
    endfunction

    localparam logic [DATA_W-1:0] MEAS_VAR_RST   = fix_of_int(DATA_W'(4));
    localparam logic [DATA_W-1:0] MOTION_VAR_RST = fix_of_int(DATA_W'(2));
    localparam logic [DATA_W-1:0] INIT_MEAN_RST  = '0;
    localparam logic [DATA_W-1:0] INIT_VAR_RST   = fix_of_int(DATA_W'(1000));

    typedef enum logic [1:0] {
        REG_MEAS_VAR,
        REG_MOTION_VAR,
        REG_INIT_MEAN,
        REG_INIT_VAR
    } t_reg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PREP,
        OP_MUL_MAG,
        OP_MUL_VAR,
        OP_ADD_HALF,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_CORR,
        OP_VAR,
        OP_DEGEN,
        OP_PRED
    } t_op;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_DEN_ZERO,
        COND_DIV_MORE,
        COND_ALWAYS
    } t_cond;

    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
        logic  last;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_ctrl;

    typedef struct packed {
        logic den_zero;
        logic div_more;
    } t_stat;

    localparam t_pc PC_CORR_DIV = t_pc'(4);
    localparam t_pc PC_VAR_DIV  = t_pc'(9);
    localparam t_pc PC_PRED     = t_pc'(11);
    localparam t_pc PC_DEGEN    = t_pc'(12);

    // control program, one word per step
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            t_pc'(0):  w = '{OP_PREP,     COND_NEVER,    '0,          1'b0};
            t_pc'(1):  w = '{OP_MUL_MAG,  COND_DEN_ZERO, PC_DEGEN,    1'b0};
            t_pc'(2):  w = '{OP_ADD_HALF, COND_NEVER,    '0,          1'b0};
            t_pc'(3):  w = '{OP_DIV_INIT, COND_NEVER,    '0,          1'b0};
            t_pc'(4):  w = '{OP_DIV_STEP, COND_DIV_MORE, PC_CORR_DIV, 1'b0};
            t_pc'(5):  w = '{OP_CORR,     COND_NEVER,    '0,          1'b0};
            t_pc'(6):  w = '{OP_MUL_VAR,  COND_NEVER,    '0,          1'b0};
            t_pc'(7):  w = '{OP_ADD_HALF, COND_NEVER,    '0,          1'b0};
            t_pc'(8):  w = '{OP_DIV_INIT, COND_NEVER,    '0,          1'b0};
            t_pc'(9):  w = '{OP_DIV_STEP, COND_DIV_MORE, PC_VAR_DIV,  1'b0};
            t_pc'(10): w = '{OP_VAR,      COND_NEVER,    '0,          1'b0};
            t_pc'(11): w = '{OP_PRED,     COND_NEVER,    '0,          1'b1};
            t_pc'(12): w = '{OP_DEGEN,    COND_ALWAYS,   PC_PRED,     1'b0};
            default:   w = '{OP_NOP,      COND_NEVER,    '0,          1'b1};
        endcase
        return w;
    endfunction

endpackage

/* src/skf_seq.sv */
// step counter and handshake control of the scalar kalman filter
// reads the control program from skf_pkg and drives skf_dpath

module skf_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  skf_pkg::t_stat i_stat,
    output skf_pkg::t_ctrl o_ctrl
);
    import skf_pkg::*;

    logic   r_busy, n_busy;
    t_pc    r_pc, n_pc;
    logic   r_out_valid, n_out_valid;
    t_uword uw;
    logic   hold, exec, accept, taken;

    always_comb begin
        uw     = ucode(r_pc);
        // the result step waits while the previous item is still unread
        hold   = r_busy && (uw.op == OP_PRED) && r_out_valid && i_out_stall;
        exec   = r_busy && !hold;
        accept = i_in_valid && !r_busy;
        case (uw.cond)
            COND_NEVER:    taken = 1'b0;
            COND_DEN_ZERO: taken = i_stat.den_zero;
            COND_DIV_MORE: taken = i_stat.div_more;
            COND_ALWAYS:   taken = 1'b1;
            default:       taken = 1'b0;
        endcase

        n_busy      = r_busy;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        if (accept) begin
            n_busy = 1'b1;
            n_pc   = '0;
        end else if (exec) begin
            if (uw.last) begin
                n_busy = 1'b0;
            end
            n_pc = taken ? uw.target : r_pc + t_pc'(1);
        end
        if (exec && (uw.op == OP_PRED)) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ctrl.op   = exec ? uw.op : OP_NOP;
    assign o_ctrl.load = accept;
    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;

endmodule

/* src/skf_dpath.sv */
// datapath of the scalar kalman filter: estimate, multiplier, divider, saturation
// uses skf_pkg; steered one operation a cycle by skf_seq, except while an output stall holds the result step

module skf_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  skf_pkg::t_ctrl             i_ctrl,
    output skf_pkg::t_stat             o_stat,
    input  logic [skf_pkg::DATA_W-1:0] i_meas_var,
    input  logic [skf_pkg::DATA_W-1:0] i_motion_var,
    input  logic [skf_pkg::DATA_W-1:0] i_init_mean,
    input  logic [skf_pkg::DATA_W-1:0] i_init_var,
    input  logic [skf_pkg::DATA_W-1:0] i_measured_value,
    input  logic [skf_pkg::DATA_W-1:0] i_motion_step,
    input  logic                       i_restart,
    output logic [skf_pkg::DATA_W-1:0] o_updated_mean,
    output logic [skf_pkg::DATA_W-1:0] o_updated_variance,
    output logic [skf_pkg::DATA_W-1:0] o_predicted_mean,
    output logic [skf_pkg::DATA_W-1:0] o_predicted_variance,
    output logic                       o_degenerate
);
    import skf_pkg::*;

    localparam int W = DATA_W;

    // estimate
    logic [W-1:0]     r_m, r_p;
    // item and working registers
    logic [W-1:0]     r_z, r_step;
    logic [W:0]       r_den;
    logic [W-1:0]     r_mag;
    logic             r_neg;
    logic [2*W-1:0]   r_prod;
    logic [2*W:0]     r_num;
    logic [W:0]       r_rem;
    logic [W-1:0]     r_dlo, r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_newm, r_newp;
    logic             r_deg;
    // result registers
    logic [W-1:0]     r_upd_mean, r_upd_var, r_pred_mean, r_pred_var;
    logic             r_out_deg;

    logic [W:0]       diff, ndiff, corr_sum, pm, pv;
    logic [W+1:0]     trial;
    logic             ge;
    logic [W-1:0]     mul_b, pm_sat, pv_sat;

    always_comb begin
        diff     = {r_z[W-1], r_z} - {r_m[W-1], r_m};
        ndiff    = -diff;
        mul_b    = (i_ctrl.op == OP_MUL_VAR) ? i_meas_var : r_mag;
        // one restoring division step
        trial    = {r_rem, r_dlo[W-1]};
        ge       = trial >= {1'b0, r_den};
        corr_sum = r_neg ? ({r_m[W-1], r_m} - {1'b0, r_quo})
                         : ({r_m[W-1], r_m} + {1'b0, r_quo});
        pm       = {r_newm[W-1], r_newm} + {r_step[W-1], r_step};
        pv       = {1'b0, r_newp} + {1'b0, i_motion_var};
        if (pm[W] != pm[W-1]) begin
            pm_sat = pm[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            pm_sat = pm[W-1:0];
        end
        pv_sat   = pv[W] ? {W{1'b1}} : pv[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= '0;
            r_p <= INIT_VAR_RST;
        end else if (i_ctrl.load) begin
            if (i_restart) begin
                r_m <= i_init_mean;
                r_p <= i_init_var;
            end
        end else if (i_ctrl.op == OP_PRED) begin
            r_m <= pm_sat;
            r_p <= pv_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_z    <= i_measured_value;
            r_step <= i_motion_step;
        end
        case (i_ctrl.op)
            OP_PREP: begin
                r_den <= {1'b0, r_p} + {1'b0, i_meas_var};
                r_neg <= diff[W];
                // |z - m| never reaches 2^32, so the magnitude fits the data width
                r_mag <= diff[W] ? ndiff[W-1:0] : diff[W-1:0];
                r_deg <= 1'b0;
            end
            OP_MUL_MAG, OP_MUL_VAR: begin
                r_prod <= r_p * mul_b;
            end
            OP_ADD_HALF: begin
                r_num <= {1'b0, r_prod} + {{W{1'b0}}, r_den[W:1]};
            end
            OP_DIV_INIT: begin
                // quotient stays below 2^32, so the top part is already below the divisor
                r_rem <= r_num[2*W:W];
                r_dlo <= r_num[W-1:0];
                r_cnt <= CNT_W'(DIV_STEPS);
            end
            OP_DIV_STEP: begin
                r_rem <= ge ? (W+1)'(trial - {1'b0, r_den}) : trial[W:0];
                r_dlo <= {r_dlo[W-2:0], 1'b0};
                r_quo <= {r_quo[W-2:0], ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_CORR: begin
                r_newm <= corr_sum[W-1:0];
            end
            OP_VAR: begin
                r_newp <= r_quo;
            end
            OP_DEGEN: begin
                r_newm <= r_m;
                r_newp <= r_p;
                r_deg  <= 1'b1;
            end
            OP_PRED: begin
                r_upd_mean  <= r_newm;
                r_upd_var   <= r_newp;
                r_pred_mean <= pm_sat;
                r_pred_var  <= pv_sat;
                r_out_deg   <= r_deg;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.den_zero     = (r_den == '0);
    assign o_stat.div_more     = (r_cnt != CNT_W'(1));
    assign o_updated_mean       = r_upd_mean;
    assign o_updated_variance   = r_upd_var;
    assign o_predicted_mean     = r_pred_mean;
    assign o_predicted_variance = r_pred_var;
    assign o_degenerate         = r_out_deg;

endmodule

/* src/scalar_kalman_filter_top.sv */
// top level of the scalar kalman filter: configuration registers and apb port
// uses skf_pkg, skf_seq and skf_dpath
//
// channel   direction  handshake                  payload
// config    in         psel, penable, pwrite      paddr, pwdata, prdata
// item in   in         i_in_valid / o_in_stall    measured value, motion step, restart
// item out  out        o_out_valid / i_out_stall  means, variances, degenerate flag
//
// an item runs the two 32-step restoring divisions of the shared divider;
// a degenerate item skips both
// one item is worked on at a time; the next is accepted once the result is loaded
// into the output registers, while that result may still wait for its reader
// synchronous reset loads the register defaults and the estimate at once
// an output stall holds only the final step of the following item

module scalar_kalman_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [skf_pkg::DATA_W-1:0] i_measured_value,
    input  logic signed [skf_pkg::DATA_W-1:0] i_motion_step,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [skf_pkg::DATA_W-1:0] o_updated_mean,
    output logic        [skf_pkg::DATA_W-1:0] o_updated_variance,
    output logic signed [skf_pkg::DATA_W-1:0] o_predicted_mean,
    output logic        [skf_pkg::DATA_W-1:0] o_predicted_variance,
    output logic                              o_degenerate
);
    import skf_pkg::*;

    logic [DATA_W-1:0] r_meas_var, r_motion_var, r_init_mean, r_init_var;
    logic [DATA_W-1:0] upd_mean, pred_mean;
    t_reg              reg_sel;
    logic              wr_en;
    t_ctrl             ctrl;
    t_stat             stat;

    assign reg_sel = t_reg'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_var   <= MEAS_VAR_RST;
            r_motion_var <= MOTION_VAR_RST;
            r_init_mean  <= INIT_MEAN_RST;
            r_init_var   <= INIT_VAR_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_MEAS_VAR:   r_meas_var   <= pwdata;
                REG_MOTION_VAR: r_motion_var <= pwdata;
                REG_INIT_MEAN:  r_init_mean  <= pwdata;
                REG_INIT_VAR:   r_init_var   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MEAS_VAR:   prdata = r_meas_var;
            REG_MOTION_VAR: prdata = r_motion_var;
            REG_INIT_MEAN:  prdata = r_init_mean;
            REG_INIT_VAR:   prdata = r_init_var;
            default:        prdata = '0;
        endcase
    end

    skf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    skf_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctrl               (ctrl),
        .o_stat               (stat),
        .i_meas_var           (r_meas_var),
        .i_motion_var         (r_motion_var),
        .i_init_mean          (r_init_mean),
        .i_init_var           (r_init_var),
        .i_measured_value     (i_measured_value),
        .i_motion_step        (i_motion_step),
        .i_restart            (i_restart),
        .o_updated_mean       (upd_mean),
        .o_updated_variance   (o_updated_variance),
        .o_predicted_mean     (pred_mean),
        .o_predicted_variance (o_predicted_variance),
        .o_degenerate         (o_degenerate)
    );

    assign o_updated_mean   = upd_mean;
    assign o_predicted_mean = pred_mean;

endmodule

/* test/scalar_kalman_filter_tb.sv */
// self-checking testbench for scalar_kalman_filter_top: directed table, then random phases
// depends on skf_pkg and scalar_kalman_filter_top; its own estimate tracker predicts results
`timescale 1ns / 1ps

module testbench;
    import skf_pkg::*;

    typedef struct packed {
        logic [31:0] meas;
        logic [31:0] motion;
        logic [31:0] init_mean;
        logic [31:0] init_var;
    } t_settings;

    typedef struct packed {
        logic [31:0] measured;
        logic [31:0] motion;
        logic        restart;
    } t_reading;

    typedef struct packed {
        logic [31:0] upd_mean;
        logic [31:0] upd_var;
        logic [31:0] pred_mean;
        logic [31:0] pred_var;
        logic        degenerate;
    } t_estimate;

    typedef struct packed {
        logic      load_cfg;
        t_settings cfg;
        t_reading  rd;
        logic      typed;
        t_estimate want;
    } t_row;

    localparam t_settings DEF_SETTINGS =
        '{MEAS_VAR_RST, MOTION_VAR_RST, INIT_MEAN_RST, INIT_VAR_RST};
    localparam t_estimate NO_EST   = '0;
    localparam longint    MEAN_HI  = 64'sd2147483647;
    localparam longint    MEAN_LO  = -64'sd2147483648;
    localparam int        N_ROWS   = 17;
    localparam int        N_PHASES = 12;
    localparam int        PHASE_ITEMS = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic signed [31:0] i_measured_value = '0;
    logic signed [31:0] i_motion_step = '0;
    logic        i_restart = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [31:0] o_updated_mean;
    logic        [31:0] o_updated_variance;
    logic signed [31:0] o_predicted_mean;
    logic        [31:0] o_predicted_variance;
    logic        o_degenerate;

    scalar_kalman_filter_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_measured_value     (i_measured_value),
        .i_motion_step        (i_motion_step),
        .i_restart            (i_restart),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_updated_mean       (o_updated_mean),
        .o_updated_variance   (o_updated_variance),
        .o_predicted_mean     (o_predicted_mean),
        .o_predicted_variance (o_predicted_variance),
        .o_degenerate         (o_degenerate)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tracked copy of the filter state and its registers
    t_settings   cfg;
    logic [31:0] est_mean;
    logic [31:0] est_var;

    t_estimate expected_estimates[$];
    int        mismatches = 0;
    int        burst_left = 0;
    int        idle_left = 0;
    int        stall_mode = 0;
    int        stall_left = 0;
    t_row      directed_rows [N_ROWS];

    function automatic t_estimate kalman_step(input t_reading rd);
        t_estimate   res;
        longint      m, z, diff, new_m, sum;
        logic [63:0] p, r, den, mag, corr, new_p, pred_p;
        if (rd.restart) begin
            est_mean = cfg.init_mean;
            est_var  = cfg.init_var;
        end
        m   = $signed(est_mean);
        z   = $signed(rd.measured);
        p   = {32'h0, est_var};
        r   = {32'h0, cfg.meas};
        den = p + r;
        res.degenerate = (den == 0);
        if (den == 0) begin
            new_m = m;
            new_p = p;
        end else begin
            // correction rounded on its magnitude, ties away from zero
            diff  = z - m;
            mag   = (diff < 0) ? -diff : diff;
            corr  = (p * mag + den / 2) / den;
            new_m = (diff < 0) ? m - longint'(corr) : m + longint'(corr);
            new_p = (p * r + den / 2) / den;
        end
        sum = new_m + $signed(rd.motion);
        if (sum > MEAN_HI) begin
            sum = MEAN_HI;
        end else if (sum < MEAN_LO) begin
            sum = MEAN_LO;
        end
        pred_p = new_p + {32'h0, cfg.motion};
        if (pred_p > 64'h0000_0000_FFFF_FFFF) begin
            pred_p = 64'h0000_0000_FFFF_FFFF;
        end
        est_mean = 32'(sum);
        est_var  = pred_p[31:0];
        res.upd_mean  = 32'(new_m);
        res.upd_var   = new_p[31:0];
        res.pred_mean = est_mean;
        res.pred_var  = est_var;
        return res;
    endfunction

    function automatic logic [31:0] rand_mean();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($urandom_range(0, 32'h00C8_0000)) - 32'h0064_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_var();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(1, 32'h0040_0000);
        endcase
    endfunction

    // called at a falling edge, returns at one with psel low again
    task automatic write_reg(input t_reg idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // registers change only once the block has handed back every item
    task automatic apply_settings(input t_settings s);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_estimates.size() != 0) @(negedge i_clk);
        write_reg(REG_MEAS_VAR, s.meas);
        write_reg(REG_MOTION_VAR, s.motion);
        write_reg(REG_INIT_MEAN, s.init_mean);
        write_reg(REG_INIT_VAR, s.init_var);
        cfg = s;
    endtask

    // called at a falling edge; valid stays high into the next item of a burst
    task automatic send_item(input t_reading rd, input logic typed, input t_estimate want);
        t_estimate predicted;
        while (idle_left > 0) begin
            i_in_valid <= 1'b0;
            idle_left--;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_measured_value <= rd.measured;
        i_motion_step    <= rd.motion;
        i_restart        <= rd.restart;
        do @(posedge i_clk); while (o_in_stall);
        predicted = kalman_step(rd);
        expected_estimates.push_back(typed ? want : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            idle_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 6);
        end
        @(negedge i_clk);
    endtask

    // receiver stall pattern: segments of free flow, light, even and heavy stalling
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_estimate got;
        t_estimate want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_updated_mean, o_updated_variance, o_predicted_mean,
                    o_predicted_variance, o_degenerate};
            if (expected_estimates.size() == 0) begin
                mismatches++;
                $display("%0t: result with no item outstanding, got %h", $time, got);
            end else begin
                want = expected_estimates.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display({"%0t: estimate mismatch\n",
                              "  updated_mean       exp %h act %h\n",
                              "  updated_variance   exp %h act %h\n",
                              "  predicted_mean     exp %h act %h\n",
                              "  predicted_variance exp %h act %h\n",
                              "  degenerate         exp %b act %b"},
                             $time, want.upd_mean, got.upd_mean,
                             want.upd_var, got.upd_var,
                             want.pred_mean, got.pred_mean,
                             want.pred_var, got.pred_var,
                             want.degenerate, got.degenerate);
                end
            end
        end
    end

    initial begin
        t_settings s;
        t_reading  rd;

        cfg      = DEF_SETTINGS;
        est_mean = '0;
        est_var  = INIT_VAR_RST;

        // load flag, cfg, measurement, motion, restart, typed flag, expected estimate
        directed_rows = '{
            // reset state and input extremes
            '{1'b0, DEF_SETTINGS, '{32'h0, 32'h0, 1'b0}, 1'b0, NO_EST},
            '{1'b0, DEF_SETTINGS, '{32'h7FFF_FFFF, 32'h0, 1'b0}, 1'b0, NO_EST},
            '{1'b0, DEF_SETTINGS, '{32'h8000_0000, 32'h8000_0000, 1'b0}, 1'b0, NO_EST},
            '{1'b0, DEF_SETTINGS, '{32'h000C_8000, 32'hFFFD_0000, 1'b1}, 1'b0, NO_EST},
            // exact measurement: the mean jumps to it, mean saturates both ways
            '{1'b1, '{32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000},
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}, 1'b1,
              '{32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0}},
            '{1'b0, DEF_SETTINGS, '{32'h8000_0000, 32'h8000_0000, 1'b0}, 1'b1,
              '{32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0001_0000, 1'b0}},
            '{1'b0, DEF_SETTINGS, '{32'h0, 32'hFFFF_FFFF, 1'b0}, 1'b1,
              '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0}},
            // both variances zero: update skipped, prediction still applied
            '{1'b1, '{32'h0, 32'h0, 32'h1234_5678, 32'h0},
              '{32'h7FFF_FFFF, 32'h0001_0000, 1'b1}, 1'b1,
              '{32'h1234_5678, 32'h0, 32'h1235_5678, 32'h0, 1'b1}},
            '{1'b0, DEF_SETTINGS, '{32'h8000_0000, 32'h8000_0000, 1'b0}, 1'b1,
              '{32'h1235_5678, 32'h0, 32'h9235_5678, 32'h0, 1'b1}},
            '{1'b0, DEF_SETTINGS, '{32'h0, 32'h7FFF_FFFF, 1'b0}, 1'b1,
              '{32'h9235_5678, 32'h0, 32'h1235_5677, 32'h0, 1'b1}},
            // full-scale variances: tie on the mean correction, variance saturates
            '{1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
              '{32'h7FFF_FFFF, 32'h0, 1'b1}, 1'b0, NO_EST},
            '{1'b0, DEF_SETTINGS, '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}, 1'b0, NO_EST},
            '{1'b0, DEF_SETTINGS, '{32'h0001_0000, 32'hFFFF_0000, 1'b0}, 1'b0, NO_EST},
            // zero prior variance: measurement has no pull
            '{1'b1, '{32'h1, 32'h0, 32'h7FFF_FFFF, 32'h0},
              '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1}, 1'b1,
              '{32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b0}},
            '{1'b0, DEF_SETTINGS, '{32'h0, 32'h8000_0000, 1'b1}, 1'b1,
              '{32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0}},
            // back to defaults
            '{1'b1, DEF_SETTINGS, '{32'h0005_0000, 32'h0001_0000, 1'b1}, 1'b0, NO_EST},
            '{1'b0, DEF_SETTINGS, '{32'hFFFB_0000, 32'h0, 1'b0}, 1'b0, NO_EST}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            if (directed_rows[i].load_cfg) begin
                apply_settings(directed_rows[i].cfg);
            end
            send_item(directed_rows[i].rd, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            s.meas      = rand_var();
            s.motion    = rand_var();
            s.init_mean = rand_mean();
            s.init_var  = rand_var();
            if (ph % 4 == 3) begin
                // degenerate phase, held there while the motion variance is zero
                s.meas     = 32'h0;
                s.init_var = 32'h0;
                s.motion   = ($urandom_range(0, 1) == 0) ? 32'h0 : rand_var();
            end
            apply_settings(s);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                rd.measured = rand_mean();
                rd.motion   = rand_mean();
                rd.restart  = (k == 0) || ($urandom_range(0, 15) == 0);
                send_item(rd, 1'b0, NO_EST);
            end
        end

        i_in_valid <= 1'b0;
        while (expected_estimates.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("scalar_kalman_filter_top verification clean");
        end else begin
            $display("scalar_kalman_filter_top verification failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("scalar_kalman_filter_top verification failed");
        $finish;
    end

endmodule

/* filelist.f */
src/skf_pkg.sv
src/skf_seq.sv
src/skf_dpath.sv
src/scalar_kalman_filter_top.sv
test/scalar_kalman_filter_tb.sv
